[rtl/eztq_pkg.sv]
package eztq_pkg;

    localparam int ANGLE_W  = 16;
    localparam int Q_W      = 16;
    localparam int XY_W     = 32;
    localparam int Z_W      = 34;
    localparam int AB_W     = 34;
    localparam int PROD_W   = 64;
    localparam int ATAN_N   = 24;

    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [Z_W-1:0]    z_t;
    typedef logic signed [AB_W-1:0]   ab_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [Q_W-1:0]    q_t;

    localparam xy_t CORDIC_GAIN = 32'sd652032874;
    localparam z_t  HALF_PI_Q30 = 34'sd1686629713;
    localparam z_t  PI_Q30      = 34'sd3373259426;
    localparam int  Q_MAX       = 32767;
    localparam int  Q_MIN       = -32768;

    function automatic z_t atan_q30(input logic [4:0] idx);
        z_t r;
        unique case (idx)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/euler_zyx_to_quaternion.sv]
// channel  | handshake                | payload
// angles   | angle_valid, angle_stall | yaw, pitch, roll (Q2.13)
// quat     | q_valid, q_stall         | q_w, q_x, q_y, q_z (Q0.15)
//
// one item per cycle while q_stall is low; the pipeline is the fold stage, the
// one-stage-per-iteration cordic lanes, two multiply stages and the sum stage.
// reset clears only the stage valid bits.
// each stage advances when it is empty or its successor moves, so bubbles
// collapse; angle_stall rises only when every stage holds an item and q_stall is high.
module euler_zyx_to_quaternion #(
    parameter int SINCOS_ITERATIONS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                angle_valid,
    output logic                                angle_stall,
    input  logic signed [eztq_pkg::ANGLE_W-1:0] yaw,
    input  logic signed [eztq_pkg::ANGLE_W-1:0] pitch,
    input  logic signed [eztq_pkg::ANGLE_W-1:0] roll,
    output logic                                q_valid,
    input  logic                                q_stall,
    output eztq_pkg::q_t                        q_w,
    output eztq_pkg::q_t                        q_x,
    output eztq_pkg::q_t                        q_y,
    output eztq_pkg::q_t                        q_z
);
    import eztq_pkg::*;

    localparam int STAGES = SINCOS_ITERATIONS + 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;
    logic [STAGES-1:0] en;

    xy_t sy, cy, sp, cp, sr, cr;

    always_comb
    begin
        ready[STAGES] = !q_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        en = ready[STAGES-1:0];
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
                valid_next[i] = en[i] ? angle_valid : valid_reg[i];
            else
                valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign angle_stall = !ready[0];
    assign q_valid     = valid_reg[STAGES-1];

    eztq_lane #(.ITER(SINCOS_ITERATIONS)) u_lane_yaw (
        .clk     (clk),
        .en      (en[SINCOS_ITERATIONS:0]),
        .angle   (yaw),
        .sin_val (sy),
        .cos_val (cy)
    );

    eztq_lane #(.ITER(SINCOS_ITERATIONS)) u_lane_pitch (
        .clk     (clk),
        .en      (en[SINCOS_ITERATIONS:0]),
        .angle   (pitch),
        .sin_val (sp),
        .cos_val (cp)
    );

    eztq_lane #(.ITER(SINCOS_ITERATIONS)) u_lane_roll (
        .clk     (clk),
        .en      (en[SINCOS_ITERATIONS:0]),
        .angle   (roll),
        .sin_val (sr),
        .cos_val (cr)
    );

    eztq_merge u_merge (
        .clk (clk),
        .en  (en[STAGES-1:SINCOS_ITERATIONS+1]),
        .sy  (sy),
        .cy  (cy),
        .sp  (sp),
        .cp  (cp),
        .sr  (sr),
        .cr  (cr),
        .q_w (q_w),
        .q_x (q_x),
        .q_y (q_y),
        .q_z (q_z)
    );

endmodule

[rtl/eztq_lane.sv]
module eztq_lane #(
    parameter int ITER = 16
) (
    input  logic                                clk,
    input  logic [ITER:0]                       en,
    input  logic signed [eztq_pkg::ANGLE_W-1:0] angle,
    output eztq_pkg::xy_t                       sin_val,
    output eztq_pkg::xy_t                       cos_val
);
    import eztq_pkg::*;

    xy_t  x_reg    [0:ITER];
    xy_t  y_reg    [0:ITER];
    z_t   z_reg    [0:ITER];
    logic flip_reg [0:ITER];

    z_t   z_half;
    z_t   z_fold;
    logic flip_next;

    // half angle in Q3.30, then fold into the cordic convergence range
    always_comb
    begin
        z_half = z_t'(angle) <<< 16;
        z_fold = z_half;
        flip_next = 1'b0;
        if (z_half > HALF_PI_Q30)
        begin
            z_fold = z_half - PI_Q30;
            flip_next = 1'b1;
        end
        else if (z_half < -HALF_PI_Q30)
        begin
            z_fold = z_half + PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar k = 1; k <= ITER; k++)
    begin : g_iter
        xy_t dx;
        xy_t dy;
        assign dx = x_reg[k-1] >>> (k-1);
        assign dy = y_reg[k-1] >>> (k-1);

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                flip_reg[k] <= flip_reg[k-1];
                if (!z_reg[k-1][Z_W-1])
                begin
                    x_reg[k] <= x_reg[k-1] - dy;
                    y_reg[k] <= y_reg[k-1] + dx;
                    z_reg[k] <= z_reg[k-1] - atan_q30(5'(k-1));
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] + dy;
                    y_reg[k] <= y_reg[k-1] - dx;
                    z_reg[k] <= z_reg[k-1] + atan_q30(5'(k-1));
                end
            end
        end
    end

    assign sin_val = flip_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];
    assign cos_val = flip_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];

endmodule

[rtl/eztq_merge.sv]
module eztq_merge (
    input  logic          clk,
    input  logic [2:0]    en,
    input  eztq_pkg::xy_t sy,
    input  eztq_pkg::xy_t cy,
    input  eztq_pkg::xy_t sp,
    input  eztq_pkg::xy_t cp,
    input  eztq_pkg::xy_t sr,
    input  eztq_pkg::xy_t cr,
    output eztq_pkg::q_t  q_w,
    output eztq_pkg::q_t  q_x,
    output eztq_pkg::q_t  q_y,
    output eztq_pkg::q_t  q_z
);
    import eztq_pkg::*;

    ab_t   cycp_reg, sysp_reg, cysp_reg, sycp_reg;
    xy_t   sr_reg, cr_reg;
    prod_t t_reg [0:7];
    q_t    qw_reg, qx_reg, qy_reg, qz_reg;

    function automatic ab_t mul_round(input xy_t a, input xy_t b);
        prod_t p;
        p = prod_t'(a) * prod_t'(b) + (prod_t'(1) <<< 29);
        return ab_t'(p >>> 30);
    endfunction

    function automatic q_t to_q15(input prod_t a, input prod_t b, input logic sub);
        prod_t s;
        prod_t v;
        s = sub ? a - b : a + b;
        v = (s + (prod_t'(1) <<< 44)) >>> 45;
        if (v > prod_t'(Q_MAX))
            return q_t'(Q_MAX);
        else if (v < prod_t'(Q_MIN))
            return q_t'(Q_MIN);
        return q_t'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cycp_reg <= mul_round(cy, cp);
            sysp_reg <= mul_round(sy, sp);
            cysp_reg <= mul_round(cy, sp);
            sycp_reg <= mul_round(sy, cp);
            sr_reg   <= sr;
            cr_reg   <= cr;
        end
        if (en[1])
        begin
            t_reg[0] <= prod_t'(cycp_reg) * prod_t'(cr_reg);
            t_reg[1] <= prod_t'(sysp_reg) * prod_t'(sr_reg);
            t_reg[2] <= prod_t'(cycp_reg) * prod_t'(sr_reg);
            t_reg[3] <= prod_t'(sysp_reg) * prod_t'(cr_reg);
            t_reg[4] <= prod_t'(cysp_reg) * prod_t'(cr_reg);
            t_reg[5] <= prod_t'(sycp_reg) * prod_t'(sr_reg);
            t_reg[6] <= prod_t'(sycp_reg) * prod_t'(cr_reg);
            t_reg[7] <= prod_t'(cysp_reg) * prod_t'(sr_reg);
        end
        if (en[2])
        begin
            qw_reg <= to_q15(t_reg[0], t_reg[1], 1'b0);
            qx_reg <= to_q15(t_reg[2], t_reg[3], 1'b1);
            qy_reg <= to_q15(t_reg[4], t_reg[5], 1'b0);
            qz_reg <= to_q15(t_reg[6], t_reg[7], 1'b1);
        end
    end

    assign q_w = qw_reg;
    assign q_x = qx_reg;
    assign q_y = qy_reg;
    assign q_z = qz_reg;

endmodule

[rtl/eztq_chk.sv]
module eztq_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         angle_stall,
    input logic         q_valid,
    input logic         q_stall,
    input eztq_pkg::q_t q_w,
    input eztq_pkg::q_t q_x,
    input eztq_pkg::q_t q_y,
    input eztq_pkg::q_t q_z
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_stall |=> q_valid && $stable(q_w) && $stable(q_x)
                               && $stable(q_y) && $stable(q_z))
        else $error("stalled result changed");

    // with the output free the pipeline always moves
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stall |-> !angle_stall)
        else $error("input stalled while output free");

    // input blocks only behind a held result
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> q_valid && q_stall)
        else $error("input stalled without backpressure");

endmodule

bind euler_zyx_to_quaternion eztq_chk u_eztq_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .angle_stall (angle_stall),
    .q_valid     (q_valid),
    .q_stall     (q_stall),
    .q_w         (q_w),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_z         (q_z)
);
